FILE: hw/rtl/dqcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Decal quad corner generator package
// Widths, fixed-point constants and the shared root/divide unit types.
// ----------------------------------------------------------------------------
package dqcg_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned SZ_W        = 22;
  localparam int unsigned SIZE_SCALE  = 50;
  localparam int unsigned MAX_DECALS  = 16;
  localparam logic [COUNT_W-1:0] LIMIT_CAP =
    COUNT_W'((MAX_DECALS > 31) ? 31 : MAX_DECALS);
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(16);

  localparam int signed FLAT_Y_LIMIT = 16220;
  localparam int unsigned ONE_Q14    = 16384;
  localparam int unsigned Q14_BITS   = 14;
  localparam int unsigned DIR_SHIFT  = 28;
  localparam int unsigned FRAC_BITS  = 22;
  localparam int unsigned NRM_SHIFT  = 9;

  localparam int unsigned SQ_W    = 32;
  localparam int unsigned ROOT_Q_W = 30;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned VEC_W   = 17;
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 23;
  localparam int unsigned PROD_W  = 41;
  localparam int unsigned ACC_W   = 42;
  localparam int unsigned NUM_W   = 46;

  localparam int unsigned ROOT_W     = 61;
  localparam int unsigned DEN2_W     = 31;
  localparam int unsigned RES_W      = 31;
  localparam int unsigned QUO_W      = 15;
  localparam int unsigned STEP_CNT_W = 5;
  localparam int unsigned SQRT_STEPS = 30;
  localparam int unsigned SQRT_TOP   = 58;
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned DIV_SHIFT  = 14;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } dqcg_op_e;

  typedef struct packed {
    logic     start;
    dqcg_op_e op;
  } dqcg_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dqcg_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dqcg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Decal quad corner generator channels
// Valid/ready interfaces for the configuration, input and corner channels.
// ----------------------------------------------------------------------------
interface dqcg_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] shadow_limit;

  modport source (output valid, output shadow_limit, input ready);
  modport sink (input valid, input shadow_limit, output ready);
endinterface

interface dqcg_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic        [15:0] decal_size;

  modport source (output valid, output func, output pos_x, output pos_y, output pos_z,
                  output norm_x, output norm_y, output norm_z, output decal_size,
                  input ready);
  modport sink (input valid, input func, input pos_x, input pos_y, input pos_z,
                input norm_x, input norm_y, input norm_z, input decal_size,
                output ready);
endinterface

interface dqcg_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  corner_index;
  logic        [3:0]  slot_index;
  logic signed [15:0] corner_x;
  logic signed [15:0] corner_y;
  logic signed [15:0] corner_z;
  logic               saturated;
  logic               last_corner;

  modport source (output valid, output corner_index, output slot_index, output corner_x,
                  output corner_y, output corner_z, output saturated, output last_corner,
                  input ready);
  modport sink (input valid, input corner_index, input slot_index, input corner_x,
                input corner_y, input corner_z, input saturated, input last_corner,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/decal_quad_corner_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Decal quad corner generator core
// Builds the four corners of a surface-aligned square decal from a point,
// a Q2.14 normal and a Q8.8 half size, one corner per output transaction.
//
//   channel  dir  handshake    payload
//   cfg_i    in   valid/ready  shadow_limit
//   in_i     in   valid/ready  func, pos_x/y/z, norm_x/y/z, decal_size
//   out_o    out  valid/ready  corner_index, slot_index, corner_x/y/z, flags
//
// New-frame and dropped add transactions end in the idle state; a flat normal
// goes straight to the corners, a degenerate one after the squares, and a
// general normal after the two 30-step square roots and four 15-step divisions
// of the shared root/divide unit. Input ready is high only between transactions.
// A stalled output holds the sequencer before each corner load. No reset sweep.
// ----------------------------------------------------------------------------
module decal_quad_corner_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  dqcg_cfg_if.sink    cfg_i,
  dqcg_in_if.sink     in_i,
  dqcg_out_if.source  out_o
);
  import dqcg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQ     = 3'd1;
  localparam logic [2:0] ST_SQRT_L = 3'd2;
  localparam logic [2:0] ST_SQRT_N = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_UMUL   = 3'd5;
  localparam logic [2:0] ST_CORNER = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  localparam logic [1:0] DIV_CX = 2'd0;
  localparam logic [1:0] DIV_CZ = 2'd1;
  localparam logic [1:0] DIV_S  = 2'd2;
  localparam logic [1:0] DIV_C  = 2'd3;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  localparam logic signed [VEC_W-1:0] VEC_ONE = VEC_W'(ONE_Q14);

  function automatic logic signed [VEC_W-1:0] pick3(
    input logic signed [VEC_W-1:0] a,
    input logic signed [VEC_W-1:0] b,
    input logic signed [VEC_W-1:0] c,
    input logic [1:0]              idx
  );
    logic signed [VEC_W-1:0] r;
    case (idx)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic signed [VEC_W-1:0] neg_round_q14(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] q;
    m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    q = (m + PROD_W'(ONE_Q14 / 2)) >> Q14_BITS;
    return p[PROD_W-1] ? VEC_W'(q) : VEC_W'(-q);
  endfunction

  function automatic logic [COORD_W:0] to_coord(
    input logic signed [COORD_W-1:0] pos,
    input logic signed [COORD_W-1:0] nrm,
    input logic signed [PROD_W-1:0]  prod
  );
    logic [ACC_W-1:0]           v;
    logic [ACC_W-FRAC_BITS-1:0] q;
    logic                       sat;
    logic [COORD_W-1:0]         c;
    v = (ACC_W'(pos) << FRAC_BITS) + (ACC_W'(nrm) << NRM_SHIFT) + ACC_W'(prod)
        + (ACC_W'(1) << (FRAC_BITS - 1));
    q = v[ACC_W-1:FRAC_BITS];
    sat = (q[ACC_W-FRAC_BITS-1:COORD_W-1] != '0) && (q[ACC_W-FRAC_BITS-1:COORD_W-1] != '1);
    if (sat) begin
      c = q[ACC_W-FRAC_BITS-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      c = q[COORD_W-1:0];
    end
    return {sat, c};
  endfunction

  logic [2:0]               state_q, state_d;
  logic [1:0]               cnt_q, cnt_d;
  logic                     launched_q, launched_d;
  logic [1:0]               div_idx_q, div_idx_d;
  logic [1:0]               corner_q, corner_d;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic [COUNT_W-1:0]       limit_q, limit_d;
  logic [COUNT_W-1:0]       eff_limit;

  logic signed [COORD_W-1:0] pos_q [3], pos_d [3];
  logic signed [COORD_W-1:0] nrm_q [3], nrm_d [3];
  logic [SZ_W-1:0]           sz_q, sz_d;
  logic [SQ_W-1:0]           acc_q, acc_d;
  logic [SQ_W-1:0]           l2_q, l2_d;
  logic [SQ_W-1:0]           n2_q, n2_d;
  logic [ROOT_Q_W-1:0]       lq_q, lq_d;
  logic [ROOT_Q_W-1:0]       nq_q, nq_d;
  logic signed [DIR_W-1:0]   cx_q, cx_d;
  logic signed [DIR_W-1:0]   cz_q, cz_d;
  logic signed [DIR_W-1:0]   s_q, s_d;
  logic signed [DIR_W-1:0]   c_q, c_d;
  logic signed [VEC_W-1:0]   u0_q, u0_d;
  logic signed [VEC_W-1:0]   u2;
  logic signed [VEC_W-1:0]   va_q [3], va_d [3];
  logic signed [VEC_W-1:0]   vb_q [3], vb_d [3];
  logic signed [COORD_W-1:0] crd_q [3], crd_d [3];
  logic [2:0]                sat_q, sat_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [VEC_W-1:0]   vsel;
  logic [COORD_W:0]          fin;
  logic [1:0]                fin_idx;

  dqcg_req_t                 unit_req;
  dqcg_rsp_t                 unit_rsp;
  logic [ROOT_W-1:0]         unit_a;
  logic [DEN2_W-1:0]         unit_b;
  logic [RES_W-1:0]          unit_res;
  logic signed [DIR_W-1:0]   dnum;
  logic [DIR_W-1:0]          dmag;
  logic [ROOT_Q_W-1:0]       dden;
  logic [NUM_W-1:0]          dm;
  logic                      dneg;
  logic [DIR_W-1:0]          dq;
  logic signed [DIR_W-1:0]   dval;

  logic                      out_valid_q, out_valid_d;
  logic                      out_free;
  logic                      out_load;
  logic [1:0]                o_corner_q;
  logic [SLOT_W-1:0]         o_slot_q;
  logic signed [COORD_W-1:0] o_x_q, o_y_q, o_z_q;
  logic                      o_sat_q;
  logic                      o_last_q;

  logic                      in_acc;
  logic                      add_ok;

  assign eff_limit = (limit_q < LIMIT_CAP) ? limit_q : LIMIT_CAP;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc = in_i.valid && in_i.ready;
  assign add_ok = in_acc && !in_i.func && (count_q < eff_limit);
  assign cfg_i.ready = 1'b1;
  assign out_free = !out_valid_q || out_o.ready;

  dqcg_root_div u_root_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (unit_req),
    .op_a_i   (unit_a),
    .op_b_i   (unit_b),
    .rsp_o    (unit_rsp),
    .result_o (unit_res)
  );

  always_comb begin
    dnum = '0;
    dden = lq_q;
    case (div_idx_q)
      DIV_CX:  begin dnum = nrm_q[0]; dden = lq_q; end
      DIV_CZ:  begin dnum = nrm_q[2]; dden = lq_q; end
      DIV_S:   begin dnum = nrm_q[1]; dden = nq_q; end
      default: begin dnum = '0;       dden = nq_q; end
    endcase
    dmag = dnum[DIR_W-1] ? DIR_W'(-dnum) : DIR_W'(dnum);
    dm   = (div_idx_q == DIV_C) ? (NUM_W'(lq_q) << Q14_BITS) : (NUM_W'(dmag) << DIR_SHIFT);
    dneg = (div_idx_q != DIV_C) && dnum[DIR_W-1];
    dq   = DIR_W'(unit_res[QUO_W-1:0]);
    dval = dneg ? DIR_W'(-dq) : DIR_W'(dq);
  end

  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = OP_SQRT;
    unit_a         = '0;
    unit_b         = '0;
    case (state_q)
      ST_SQRT_L: unit_a = ROOT_W'(l2_q) << DIR_SHIFT;
      ST_SQRT_N: unit_a = ROOT_W'(n2_q) << DIR_SHIFT;
      ST_DIV: begin
        unit_req.op = OP_DIV;
        unit_a      = ROOT_W'({dm, 1'b0}) + ROOT_W'(dden);
        unit_b      = DEN2_W'({dden, 1'b0});
      end
      default: ;
    endcase
    if ((state_q == ST_SQRT_L || state_q == ST_SQRT_N || state_q == ST_DIV)
        && !launched_q && !unit_rsp.busy) begin
      unit_req.start = 1'b1;
    end
  end

  always_comb begin
    vsel  = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        vsel  = pick3(VEC_W'(nrm_q[0]), VEC_W'(nrm_q[2]), VEC_W'(nrm_q[1]), cnt_q);
        mul_a = MUL_A_W'(vsel);
        mul_b = MUL_B_W'(vsel);
      end
      ST_UMUL: begin
        mul_a = (cnt_q == 2'd0) ? MUL_A_W'(cx_q) : MUL_A_W'(cz_q);
        mul_b = MUL_B_W'(s_q);
      end
      ST_CORNER: begin
        if (corner_q == 2'd0 || corner_q == 2'd3) begin
          vsel = pick3(vb_q[0], vb_q[1], vb_q[2], cnt_q);
        end else begin
          vsel = pick3(va_q[0], va_q[1], va_q[2], cnt_q);
        end
        mul_a = corner_q[1] ? MUL_A_W'(vsel) : -MUL_A_W'(vsel);
        mul_b = MUL_B_W'(signed'({1'b0, sz_q}));
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign u2    = neg_round_q14(prod_q);
  assign fin_idx = cnt_q - 2'd1;
  assign fin = to_coord(pos_q[fin_idx], nrm_q[fin_idx], prod_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    launched_d  = launched_q;
    div_idx_d   = div_idx_q;
    corner_d    = corner_q;
    count_d     = count_q;
    limit_d     = limit_q;
    pos_d       = pos_q;
    nrm_d       = nrm_q;
    sz_d        = sz_q;
    acc_d       = acc_q;
    l2_d        = l2_q;
    n2_d        = n2_q;
    lq_d        = lq_q;
    nq_d        = nq_q;
    cx_d        = cx_q;
    cz_d        = cz_q;
    s_d         = s_q;
    c_d         = c_q;
    u0_d        = u0_q;
    va_d        = va_q;
    vb_d        = vb_q;
    crd_d       = crd_q;
    sat_d       = sat_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    if (cfg_i.valid) begin
      limit_d = cfg_i.shadow_limit;
    end
    if (unit_req.start) begin
      launched_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.func) begin
          count_d = '0;
        end
        if (add_ok) begin
          pos_d[0] = in_i.pos_x;
          pos_d[1] = in_i.pos_y;
          pos_d[2] = in_i.pos_z;
          nrm_d[0] = in_i.norm_x;
          nrm_d[1] = in_i.norm_y;
          nrm_d[2] = in_i.norm_z;
          sz_d     = SZ_W'(in_i.decal_size) * SZ_W'(SIZE_SCALE);
          cnt_d    = '0;
          corner_d = '0;
          if (in_i.norm_y > DIR_W'(FLAT_Y_LIMIT)) begin
            va_d[0] = -VEC_ONE;
            va_d[1] = '0;
            va_d[2] = -VEC_ONE;
            vb_d[0] = VEC_ONE;
            vb_d[1] = '0;
            vb_d[2] = -VEC_ONE;
            state_d = ST_CORNER;
          end else begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        cnt_d = cnt_q + 2'd1;
        case (cnt_q)
          2'd1: acc_d = SQ_W'(prod_q);
          2'd2: l2_d  = acc_q + SQ_W'(prod_q);
          2'd3: begin
            n2_d = l2_q + SQ_W'(prod_q);
            if (l2_q == '0) begin
              for (int i = 0; i < 3; i++) begin
                va_d[i] = '0;
                vb_d[i] = '0;
              end
              corner_d = '0;
              state_d  = ST_CORNER;
            end else begin
              state_d = ST_SQRT_L;
            end
          end
          default: ;
        endcase
      end
      ST_SQRT_L: begin
        if (unit_rsp.done) begin
          lq_d       = unit_res[ROOT_Q_W-1:0];
          launched_d = 1'b0;
          state_d    = ST_SQRT_N;
        end
      end
      ST_SQRT_N: begin
        if (unit_rsp.done) begin
          nq_d       = unit_res[ROOT_Q_W-1:0];
          launched_d = 1'b0;
          div_idx_d  = DIV_CX;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (unit_rsp.done) begin
          launched_d = 1'b0;
          case (div_idx_q)
            DIV_CX:  cx_d = dval;
            DIV_CZ:  cz_d = dval;
            DIV_S:   s_d  = dval;
            default: c_d  = dval;
          endcase
          if (div_idx_q == DIV_C) begin
            cnt_d   = '0;
            state_d = ST_UMUL;
          end else begin
            div_idx_d = div_idx_q + 2'd1;
          end
        end
      end
      ST_UMUL: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd1) begin
          u0_d = neg_round_q14(prod_q);
        end
        if (cnt_q == 2'd2) begin
          va_d[0] = -VEC_W'(cz_q) - u0_q;
          va_d[1] = -VEC_W'(c_q);
          va_d[2] = VEC_W'(cx_q) - u2;
          vb_d[0] = -VEC_W'(cz_q) + u0_q;
          vb_d[1] = VEC_W'(c_q);
          vb_d[2] = VEC_W'(cx_q) + u2;
          cnt_d    = '0;
          corner_d = '0;
          state_d  = ST_CORNER;
        end
      end
      ST_CORNER: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q != 2'd0) begin
          crd_d[fin_idx] = fin[COORD_W-1:0];
          sat_d[fin_idx] = fin[COORD_W];
        end
        if (cnt_q == 2'd3) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (corner_q == CORNER_LAST) begin
            count_d = count_q + 1'b1;
            state_d = ST_IDLE;
          end else begin
            corner_d = corner_q + 2'd1;
            state_d  = ST_CORNER;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      launched_q  <= 1'b0;
      div_idx_q   <= DIV_CX;
      corner_q    <= '0;
      count_q     <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      launched_q  <= launched_d;
      div_idx_q   <= div_idx_d;
      corner_q    <= corner_d;
      count_q     <= count_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    pos_q  <= pos_d;
    nrm_q  <= nrm_d;
    sz_q   <= sz_d;
    acc_q  <= acc_d;
    l2_q   <= l2_d;
    n2_q   <= n2_d;
    lq_q   <= lq_d;
    nq_q   <= nq_d;
    cx_q   <= cx_d;
    cz_q   <= cz_d;
    s_q    <= s_d;
    c_q    <= c_d;
    u0_q   <= u0_d;
    va_q   <= va_d;
    vb_q   <= vb_d;
    crd_q  <= crd_d;
    sat_q  <= sat_d;
    if (out_load) begin
      o_corner_q <= corner_q;
      o_slot_q   <= count_q[SLOT_W-1:0];
      o_x_q      <= crd_q[0];
      o_y_q      <= crd_q[1];
      o_z_q      <= crd_q[2];
      o_sat_q    <= |sat_q;
      o_last_q   <= (corner_q == CORNER_LAST);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.corner_index = o_corner_q;
  assign out_o.slot_index   = o_slot_q;
  assign out_o.corner_x     = o_x_q;
  assign out_o.corner_y     = o_y_q;
  assign out_o.corner_z     = o_z_q;
  assign out_o.saturated    = o_sat_q;
  assign out_o.last_corner  = o_last_q;

`ifndef NO_ASSERTIONS
  a_new_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.func |=> count_q == '0)
    else $error("new-frame transaction did not clear the decal count");

  a_done_after_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_rsp.done |-> launched_q)
    else $error("root/divide unit finished without a launch");

  a_drop_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.func && !add_ok |=> $stable(count_q) && state_q == ST_IDLE)
    else $error("add over the limit was not dropped");

  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && out_free && corner_q == CORNER_LAST
    |=> count_q == COUNT_W'($past(count_q) + 1'b1))
    else $error("decal count did not advance after the last corner");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/dqcg_root_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared root/divide unit
// One compare-subtract datapath, stepped as a restoring square root (two
// radicand bits per cycle) or a restoring divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module dqcg_root_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dqcg_pkg::dqcg_req_t                req_i,
  input  logic [dqcg_pkg::ROOT_W-1:0]        op_a_i,
  input  logic [dqcg_pkg::DEN2_W-1:0]        op_b_i,
  output dqcg_pkg::dqcg_rsp_t                rsp_o,
  output logic [dqcg_pkg::RES_W-1:0]         result_o
);
  import dqcg_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  dqcg_op_e              op_q, op_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [ROOT_W-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]     aux_q, aux_d;
  logic [ROOT_W-1:0]     step_q, step_d;
  logic [ROOT_W-1:0]     cmp_b;
  logic [ROOT_W-1:0]     diff;
  logic                  ge;

  assign cmp_b = (op_q == OP_SQRT) ? (aux_q | step_q) : step_q;
  assign ge    = rem_q >= cmp_b;
  assign diff  = rem_q - cmp_b;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    aux_d  = aux_q;
    step_d = step_q;
    if (busy_q) begin
      if (ge) begin
        rem_d = diff;
      end
      if (op_q == OP_SQRT) begin
        aux_d  = ge ? ((aux_q >> 1) | step_q) : (aux_q >> 1);
        step_d = step_q >> 2;
      end else begin
        aux_d  = {aux_q[ROOT_W-2:0], ge};
        step_d = step_q >> 1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      rem_d  = op_a_i;
      aux_d  = '0;
      if (req_i.op == OP_SQRT) begin
        step_d = ROOT_W'(1) << SQRT_TOP;
        cnt_d  = STEP_CNT_W'(SQRT_STEPS - 1);
      end else begin
        step_d = ROOT_W'(op_b_i) << DIV_SHIFT;
        cnt_d  = STEP_CNT_W'(DIV_STEPS - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    aux_q  <= aux_d;
    step_q <= step_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign result_o   = aux_q[RES_W-1:0];

endmodule
`default_nettype wire
